### rtl/sync_type_len_checksum_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SYNC_TYPE_LEN_CHECKSUM_FRAME_PARSER_MACROS_SVH
`define SYNC_TYPE_LEN_CHECKSUM_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define STLCFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STLCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/stlcfp_pkg.sv
// ----------------------------------------------------------------------------
// stlcfp_pkg
// Shared constants, codes and types of the frame parser.
// ----------------------------------------------------------------------------
package stlcfp_pkg;

  localparam int MaxPayload = 16;
  localparam int CountW     = 16;
  localparam int HandMinLen = 9;
  localparam int StoreBytes = HandMinLen;
  localparam int LenW       = $clog2(MaxPayload + 1);
  localparam int TdataW     = 136;

  localparam logic [7:0] SyncA       = 8'hAA;
  localparam logic [7:0] SyncB       = 8'h55;
  localparam logic [7:0] TypeHand    = 8'h01;
  localparam logic [7:0] TypeSwipe   = 8'h02;
  localparam logic [7:0] TypeGesture = 8'h03;
  localparam logic [7:0] NoGesture   = 8'hFF;
  localparam logic [7:0] SwipeLeft   = 8'h01;
  localparam logic [7:0] SwipeRight  = 8'h02;

  localparam logic [1:0] KindByte  = 2'd0;
  localparam logic [1:0] KindTake  = 2'd1;
  localparam logic [1:0] KindClear = 2'd2;

  localparam logic [1:0] StatNone = 2'd0;
  localparam logic [1:0] StatGood = 2'd1;
  localparam logic [1:0] StatBad  = 2'd2;

  localparam logic [1:0] TakenNone  = 2'd0;
  localparam logic [1:0] TakenLeft  = 2'd1;
  localparam logic [1:0] TakenRight = 2'd2;

  typedef struct packed {
    logic                          good;
    logic                          bad;
    logic [7:0]                    kind;
    logic [LenW-1:0]               len;
    logic [StoreBytes-1:0][7:0]    data;
  } frame_evt_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic        hand_seen;
    logic [15:0] hand_x;
    logic [15:0] hand_y;
    logic [15:0] hand_w;
    logic [15:0] hand_h;
    logic [7:0]  gesture_code;
    logic [7:0]  gesture_confidence;
    logic [1:0]  swipe_taken;
    logic [15:0] good_frames;
    logic [15:0] bad_frames;
    logic [15:0] swipe_frames;
  } res_t;

endpackage

### rtl/stlcfp_parser.sv
// ----------------------------------------------------------------------------
// stlcfp_parser
// Sync hunt, header capture, payload store and running sum check.
// ----------------------------------------------------------------------------
`include "sync_type_len_checksum_frame_parser_macros.svh"

module stlcfp_parser (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [7:0]              rx_byte,
  output stlcfp_pkg::frame_evt_t  evt
);
  import stlcfp_pkg::*;

  localparam logic [2:0] PhSync1 = 3'd0;
  localparam logic [2:0] PhSync2 = 3'd1;
  localparam logic [2:0] PhType  = 3'd2;
  localparam logic [2:0] PhLen   = 3'd3;
  localparam logic [2:0] PhData  = 3'd4;
  localparam logic [2:0] PhCheck = 3'd5;

  logic [2:0]                 phase_r, phase_nxt;
  logic [7:0]                 kind_r, kind_nxt;
  logic [LenW-1:0]            len_r, len_nxt;
  logic [LenW-1:0]            idx_r, idx_nxt;
  logic [7:0]                 sum_r, sum_nxt;
  logic [StoreBytes-1:0][7:0] store_r;
  logic                       store_we;
  logic                       chk_ok;

  assign chk_ok = (sum_r == rx_byte);

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    store_we  = 1'b0;
    unique case (phase_r)
      PhSync1: begin
        if (rx_byte == SyncA) phase_nxt = PhSync2;
      end
      PhSync2: begin
        if (rx_byte == SyncB) phase_nxt = PhType;
        else if (rx_byte != SyncA) phase_nxt = PhSync1;
      end
      PhType: begin
        kind_nxt  = rx_byte;
        phase_nxt = PhLen;
      end
      PhLen: begin
        len_nxt = LenW'(rx_byte);
        idx_nxt = '0;
        sum_nxt = kind_r;
        if (rx_byte > 8'(MaxPayload)) phase_nxt = PhSync1;
        else if (rx_byte == 8'd0) phase_nxt = PhCheck;
        else phase_nxt = PhData;
      end
      PhData: begin
        store_we = 1'b1;
        idx_nxt  = idx_r + LenW'(1);
        sum_nxt  = sum_r + rx_byte;
        if (idx_nxt >= len_r) phase_nxt = PhCheck;
      end
      PhCheck: begin
        phase_nxt = PhSync1;
      end
      default: begin
        phase_nxt = PhSync1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PhSync1;
      kind_r  <= '0;
      len_r   <= '0;
      idx_r   <= '0;
      sum_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < StoreBytes; k++) begin
      if (step && store_we && idx_r == LenW'(k)) store_r[k] <= rx_byte;
    end
  end

  always_comb begin
    evt.good = step && (phase_r == PhCheck) && chk_ok;
    evt.bad  = step && (phase_r == PhCheck) && !chk_ok;
    evt.kind = kind_r;
    evt.len  = len_r;
    evt.data = store_r;
  end

  `STLCFP_ASSERT_NEXT(a_check_resyncs, step && phase_r == PhCheck, phase_r == PhSync1,
    "phase did not return to sync hunt after check byte")
  `STLCFP_ASSERT_NOW(a_data_in_range, phase_r == PhData,
    len_r != '0 && idx_r < len_r && len_r <= LenW'(MaxPayload),
    "payload index or length out of range")

endmodule

### rtl/stlcfp_cache.sv
// ----------------------------------------------------------------------------
// stlcfp_cache
// Cached hand, gesture and swipe fields, frame counters, swipe take/clear.
// ----------------------------------------------------------------------------
`include "sync_type_len_checksum_frame_parser_macros.svh"

module stlcfp_cache (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [1:0]              kind,
  input  stlcfp_pkg::frame_evt_t  evt,
  output stlcfp_pkg::res_t        res
);
  import stlcfp_pkg::*;

  logic              present_r, present_nxt;
  logic [3:0][15:0]  box_r, box_nxt;
  logic [7:0]        gest_r, gest_nxt;
  logic [7:0]        conf_r, conf_nxt;
  logic [1:0]        flags_r, flags_nxt;
  logic [CountW-1:0] good_r, good_nxt;
  logic [CountW-1:0] bad_r, bad_nxt;
  logic [CountW-1:0] swp_r, swp_nxt;
  logic [1:0]        taken;

  always_comb begin
    present_nxt = present_r;
    box_nxt     = box_r;
    gest_nxt    = gest_r;
    conf_nxt    = conf_r;
    flags_nxt   = flags_r;
    good_nxt    = good_r;
    bad_nxt     = bad_r;
    swp_nxt     = swp_r;
    taken       = TakenNone;
    if (evt.bad) bad_nxt = bad_r + CountW'(1);
    if (evt.good) begin
      good_nxt = good_r + CountW'(1);
      if (evt.kind == TypeHand && evt.len >= LenW'(HandMinLen)) begin
        present_nxt = evt.data[0][0];
        for (int k = 0; k < 4; k++) begin
          box_nxt[k] = {evt.data[2 + 2 * k], evt.data[1 + 2 * k]};
        end
      end else if (evt.kind == TypeSwipe && evt.len != '0) begin
        if (evt.data[0] == SwipeLeft) flags_nxt[0] = 1'b1;
        else if (evt.data[0] == SwipeRight) flags_nxt[1] = 1'b1;
        swp_nxt = swp_r + CountW'(1);
      end else if (evt.kind == TypeGesture && evt.len >= LenW'(2)) begin
        gest_nxt = evt.data[0];
        conf_nxt = evt.data[1];
      end
    end
    unique case (kind)
      KindTake: begin
        if (flags_r[0]) begin
          flags_nxt[0] = 1'b0;
          taken        = TakenLeft;
        end else if (flags_r[1]) begin
          flags_nxt[1] = 1'b0;
          taken        = TakenRight;
        end
      end
      KindClear: begin
        flags_nxt = 2'b00;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= 1'b0;
      box_r     <= '0;
      gest_r    <= NoGesture;
      conf_r    <= '0;
      flags_r   <= '0;
      good_r    <= '0;
      bad_r     <= '0;
      swp_r     <= '0;
    end else if (step) begin
      present_r <= present_nxt;
      box_r     <= box_nxt;
      gest_r    <= gest_nxt;
      conf_r    <= conf_nxt;
      flags_r   <= flags_nxt;
      good_r    <= good_nxt;
      bad_r     <= bad_nxt;
      swp_r     <= swp_nxt;
    end
  end

  always_comb begin
    res.frame_status       = evt.good ? StatGood : (evt.bad ? StatBad : StatNone);
    res.hand_seen          = present_nxt;
    res.hand_x             = box_nxt[0];
    res.hand_y             = box_nxt[1];
    res.hand_w             = box_nxt[2];
    res.hand_h             = box_nxt[3];
    res.gesture_code       = gest_nxt;
    res.gesture_confidence = conf_nxt;
    res.swipe_taken        = step ? taken : TakenNone;
    res.good_frames        = 16'(good_nxt);
    res.bad_frames         = 16'(bad_nxt);
    res.swipe_frames       = 16'(swp_nxt);
  end

  `STLCFP_ASSERT_NEXT(a_good_counts, evt.good, good_r == $past(good_r) + CountW'(1),
    "good frame counter did not advance")
  `STLCFP_ASSERT_NEXT(a_take_clears, step && kind == KindTake && flags_r != 2'b00,
    $countones(flags_r) == $countones($past(flags_r)) - 1,
    "taking a swipe did not clear exactly one flag")

endmodule

### rtl/sync_type_len_checksum_frame_parser.sv
// ----------------------------------------------------------------------------
// sync_type_len_checksum_frame_parser
// Byte-stream frame parser with cached hand, gesture and swipe fields.
// ----------------------------------------------------------------------------
// Accepts one item per clock and returns exactly one result item per input
// item, in order. An item is captured in an input register, passes the
// parser and field cache, and lands in the output register. The single
// pass through the phase, sum and cache update sets the rate of one item
// per cycle; a stalled output holds the pipeline.
module sync_type_len_checksum_frame_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,  // [7:0] rx_byte
  input  logic [1:0]                      in_tuser,  // [1:0] kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] frame_status, [2] hand_seen, [18:3] hand_x, [34:19] hand_y,
  // [50:35] hand_w, [66:51] hand_h, [74:67] gesture_code,
  // [82:75] gesture_confidence, [84:83] swipe_taken, [100:85] good_frames,
  // [116:101] bad_frames, [132:117] swipe_frames, [135:133] zero
  output logic [stlcfp_pkg::TdataW-1:0]   out_tdata
);
  import stlcfp_pkg::*;

  logic       s1_valid_r;
  logic [1:0] s1_kind_r;
  logic [7:0] s1_byte_r;
  logic       adv;
  logic       out_valid_r;
  res_t       res;
  res_t       res_r;
  frame_evt_t evt;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r <= in_tuser;
      s1_byte_r <= in_tdata;
    end
  end

  stlcfp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv && s1_kind_r == KindByte),
    .rx_byte (s1_byte_r),
    .evt     (evt)
  );

  stlcfp_cache u_cache (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .kind  (s1_kind_r),
    .evt   (evt),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.swipe_frames, res_r.bad_frames, res_r.good_frames,
                       res_r.swipe_taken, res_r.gesture_confidence, res_r.gesture_code,
                       res_r.hand_h, res_r.hand_w, res_r.hand_y, res_r.hand_x,
                       res_r.hand_seen, res_r.frame_status};

endmodule
